[hdl/gdau_pkg.sv]
// ----------------------------------------------------------------------------
// gdau_pkg - shared types, constants and calendar tables
// Widths, status and function codes, and month tables for the date unit.
// ----------------------------------------------------------------------------
package gdau_pkg;

	localparam int CFG_W           = 12;
	localparam int DAY_W           = 5;
	localparam int MON_W           = 4;
	localparam int DIFF_W          = 22;
	localparam int DEF_YEAR_BITS   = 12;
	localparam int DEF_OFFSET_BITS = 21;

	// day numbers count from March 1 of year -YEAR_SHIFT
	localparam int YEAR_SHIFT   = 400;
	localparam int DAYS_400Y    = 146097;
	localparam int MAX_CFG_YEAR = (1 << CFG_W) - 1;
	localparam int YY_MAX       = MAX_CFG_YEAR + YEAR_SHIFT;
	// day number of December 31 of the largest year a result may carry
	localparam int N_MAX        = 365 * YY_MAX + YY_MAX / 4 - YY_MAX / 100 + YY_MAX / 400 + 305;
	localparam int N_W          = $clog2(N_MAX + 1);
	localparam int ERA_MAX      = N_MAX / DAYS_400Y;
	localparam int ERA_W        = $clog2(ERA_MAX + 1);
	localparam int DOE_W        = $clog2(DAYS_400Y);
	localparam int YOE_W        = 9;
	localparam int DOY_W        = 9;
	localparam int YSH_W        = $clog2(YY_MAX + 2);

	localparam int RESET_MIN_YEAR = 1902;
	localparam int RESET_MAX_YEAR = 2037;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_BAD_DATE = 2'd1,
		STAT_RANGE    = 2'd2
	} status_t;

	typedef enum logic {
		FUNC_ADD  = 1'b0,
		FUNC_DIFF = 1'b1
	} func_t;

	typedef enum logic {
		REG_MIN_YEAR = 1'b0,
		REG_MAX_YEAR = 1'b1
	} cfg_reg_t;

	// day number width for a given year width
	function automatic int dn_width(input int year_bits);
		return year_bits + 11;
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m);
		logic [DAY_W-1:0] len;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = 5'd29;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	// first day of month, counted in a March-based year
	function automatic logic [DOY_W-1:0] march_start(input logic [3:0] mp);
		logic [DOY_W-1:0] s;
		unique case (mp)
			4'd0:    s = 9'd0;
			4'd1:    s = 9'd31;
			4'd2:    s = 9'd61;
			4'd3:    s = 9'd92;
			4'd4:    s = 9'd122;
			4'd5:    s = 9'd153;
			4'd6:    s = 9'd184;
			4'd7:    s = 9'd214;
			4'd8:    s = 9'd245;
			4'd9:    s = 9'd275;
			4'd10:   s = 9'd306;
			4'd11:   s = 9'd337;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

	// same table indexed by calendar month
	function automatic logic [DOY_W-1:0] month_base(input logic [MON_W-1:0] m);
		logic [DOY_W-1:0] s;
		unique case (m)
			4'd3:    s = march_start(4'd0);
			4'd4:    s = march_start(4'd1);
			4'd5:    s = march_start(4'd2);
			4'd6:    s = march_start(4'd3);
			4'd7:    s = march_start(4'd4);
			4'd8:    s = march_start(4'd5);
			4'd9:    s = march_start(4'd6);
			4'd10:   s = march_start(4'd7);
			4'd11:   s = march_start(4'd8);
			4'd12:   s = march_start(4'd9);
			4'd1:    s = march_start(4'd10);
			4'd2:    s = march_start(4'd11);
			default: s = 9'd0;
		endcase
		return s;
	endfunction

endpackage

[hdl/gdau_daynum.sv]
// ----------------------------------------------------------------------------
// gdau_daynum - date check and date to day number, two stages
// Stage 1 splits the year by 100 and scales by 365, stage 2 sums the terms.
// ----------------------------------------------------------------------------
module gdau_daynum import gdau_pkg::*; #(
	parameter int YEAR_BITS = DEF_YEAR_BITS
) (
	input  logic                           clk,
	input  logic [1:0]                     en,
	input  logic [DAY_W-1:0]               day,
	input  logic [MON_W-1:0]               month,
	input  logic [YEAR_BITS-1:0]           year,
	output logic [dn_width(YEAR_BITS)-1:0] dn,
	output logic                           ok
);

	localparam int YY_W = YEAR_BITS + 2;
	localparam int DN_W = dn_width(YEAR_BITS);
	localparam int QW   = YY_W - 6;
	localparam int K100 = YY_W + 7;
	localparam int PW   = 2 * YY_W + 1;
	localparam logic [YY_W:0] M100 = (YY_W + 1)'(((64'd1 << K100) + 64'd99) / 64'd100);

	logic [YY_W-1:0]  y_ext, yy;
	logic [PW-1:0]    prod_y, prod_yy;
	logic [DOY_W-1:0] doy;
	logic             basic_ok, feb29;

	logic [YY_W-1:0]  y_s1, yy_s1;
	logic [QW-1:0]    qy_s1, qyy_s1;
	logic [DN_W-1:0]  m365_s1;
	logic [DOY_W-1:0] doy_s1;
	logic             basic_ok_s1, feb29_s1;

	logic [YY_W-1:0]  hund;
	logic             leap;
	logic [DN_W-1:0]  dn_s2;
	logic             ok_s2;

	always_comb begin
		y_ext    = YY_W'(year);
		yy       = y_ext + YY_W'(YEAR_SHIFT) - YY_W'(month <= 4'd2);
		prod_y   = PW'(y_ext) * PW'(M100);
		prod_yy  = PW'(yy) * PW'(M100);
		doy      = month_base(month) + DOY_W'(day) - DOY_W'(1);
		basic_ok = (month >= 4'd1) && (month <= 4'd12) && (day != '0) &&
			(day <= month_len(month));
		feb29    = (month == 4'd2) && (day == 5'd29);
	end

	always_comb begin
		hund = YY_W'(qy_s1) * YY_W'(100);
		leap = (y_s1[1:0] == 2'b00) && ((y_s1 != hund) || (qy_s1[1:0] == 2'b00));
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			y_s1        <= y_ext;
			yy_s1       <= yy;
			qy_s1       <= prod_y[PW-1:K100];
			qyy_s1      <= prod_yy[PW-1:K100];
			m365_s1     <= DN_W'(yy) * DN_W'(365);
			doy_s1      <= doy;
			basic_ok_s1 <= basic_ok;
			feb29_s1    <= feb29;
		end
		if (en[1]) begin
			// 365*yy + yy/4 - yy/100 + yy/400 + day of March-based year
			dn_s2 <= m365_s1 + DN_W'(yy_s1 >> 2) - DN_W'(qyy_s1) + DN_W'(qyy_s1 >> 2) +
				DN_W'(doy_s1);
			ok_s2 <= basic_ok_s1 && (!feb29_s1 || leap);
		end
	end

	assign dn = dn_s2;
	assign ok = ok_s2;

endmodule

[hdl/gdau_civil.sv]
// ----------------------------------------------------------------------------
// gdau_civil - day number back to year, month and day, seven stages
// Era, day of era, year of era, day of year, then month and day.
// ----------------------------------------------------------------------------
module gdau_civil import gdau_pkg::*; (
	input  logic             clk,
	input  logic [6:0]       en,
	input  logic [N_W-1:0]   n,
	output logic [YSH_W-1:0] year_sh,
	output logic [MON_W-1:0] month,
	output logic [DAY_W-1:0] day
);

	localparam int PW     = 2 * DOE_W + 1;
	localparam int K1460  = DOE_W + 11;
	localparam int K36524 = DOE_W + 16;
	localparam int K365   = DOE_W + 9;
	localparam logic [DOE_W:0] M1460  = (DOE_W + 1)'(((64'd1 << K1460) + 64'd1459) / 64'd1460);
	localparam logic [DOE_W:0] M36524 =
		(DOE_W + 1)'(((64'd1 << K36524) + 64'd36523) / 64'd36524);
	localparam logic [DOE_W:0] M365   = (DOE_W + 1)'(((64'd1 << K365) + 64'd364) / 64'd365);

	logic [ERA_W-1:0] era;
	logic [PW-1:0]    prod1460, prod36524, prod365;
	logic [1:0]       cent;
	logic [3:0]       mp;
	logic [MON_W-1:0] mm;

	logic [N_W-1:0]         n_s4;
	logic [ERA_W-1:0]       era_s4, era_s5, era_s6, era_s7, era_s8;
	logic [DOE_W-1:0]       doe_s5, doe_s6, doe_s7, doe_s8;
	logic [PW-K1460-1:0]    q1460_s6;
	logic [PW-K36524-1:0]   q36524_s6;
	logic                   last_s6;
	logic [DOE_W-1:0]       t_s7;
	logic [YOE_W-1:0]       yoe_s8;
	logic [DOY_W-1:0]       doy_s9;
	logic [YSH_W-1:0]       ybase_s9;
	logic [YSH_W-1:0]       year_sh_s10;
	logic [MON_W-1:0]       month_s10;
	logic [DAY_W-1:0]       day_s10;

	always_comb begin
		era = '0;
		for (int k = 1; k <= ERA_MAX; k++) begin
			if (n >= N_W'(k * DAYS_400Y))
				era = ERA_W'(k);
		end
	end

	always_comb begin
		prod1460  = PW'(doe_s5) * PW'(M1460);
		prod36524 = PW'(doe_s5) * PW'(M36524);
		prod365   = PW'(t_s7) * PW'(M365);
		cent      = 2'(yoe_s8 >= 9'd100) + 2'(yoe_s8 >= 9'd200) + 2'(yoe_s8 >= 9'd300);
	end

	always_comb begin
		mp = '0;
		for (int k = 1; k < 12; k++) begin
			if (doy_s9 >= march_start(4'(k)))
				mp = 4'(k);
		end
		mm = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			n_s4   <= n;
			era_s4 <= era;
		end
		if (en[1]) begin
			doe_s5 <= DOE_W'(n_s4 - N_W'(era_s4) * N_W'(DAYS_400Y));
			era_s5 <= era_s4;
		end
		if (en[2]) begin
			q1460_s6  <= prod1460[PW-1:K1460];
			q36524_s6 <= prod36524[PW-1:K36524];
			last_s6   <= (doe_s5 == DOE_W'(DAYS_400Y - 1));
			doe_s6    <= doe_s5;
			era_s6    <= era_s5;
		end
		if (en[3]) begin
			t_s7   <= doe_s6 - DOE_W'(q1460_s6) + DOE_W'(q36524_s6) - DOE_W'(last_s6);
			doe_s7 <= doe_s6;
			era_s7 <= era_s6;
		end
		if (en[4]) begin
			yoe_s8 <= YOE_W'(prod365[PW-1:K365]);
			doe_s8 <= doe_s7;
			era_s8 <= era_s7;
		end
		if (en[5]) begin
			doy_s9   <= DOY_W'(doe_s8 - (DOE_W'(yoe_s8) * DOE_W'(365) + DOE_W'(yoe_s8 >> 2) -
				DOE_W'(cent)));
			ybase_s9 <= YSH_W'(yoe_s8) + YSH_W'(era_s8) * YSH_W'(400);
		end
		if (en[6]) begin
			day_s10     <= DAY_W'(doy_s9 - march_start(mp) + DOY_W'(1));
			month_s10   <= mm;
			// January and February belong to the next calendar year
			year_sh_s10 <= ybase_s9 + YSH_W'(mm <= 4'd2);
		end
	end

	assign year_sh = year_sh_s10;
	assign month   = month_s10;
	assign day     = day_s10;

endmodule

[hdl/gregorian_date_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic_unit - date plus days and date difference
// Proleptic Gregorian calendar, exact day-number arithmetic, 11 stages.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries func, dates A and B and
//   offset_days. An item is taken at a clock edge with in_valid high and
//   in_stall low. func = add returns A + offset_days as res_day/month/year;
//   func = diff returns A - B in day_difference, saturated to 22 bits.
//   a_before_b / a_equals_b compare the raw fields in both modes.
//   Output channel out_valid/out_stall gives one result per item, in order.
//   One item per cycle is sustained while out_stall is low, through the
//   eleven-stage pipeline (two day-number stages, one add/compare stage,
//   seven stages of day-number to date conversion, one output stage).
//   out_stall holds the output register; earlier stages keep filling empty
//   slots, so in_stall rises only once every stage holds an item.
//   min_year/max_year are written through cfg_we/cfg_idx/cfg_data, by the user
//   only while the unit is idle (the unit does not enforce this). Reset empties
//   the pipeline and loads the year limits with 1902 and 2037.
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic_unit import gdau_pkg::*; #(
	parameter int YEAR_BITS   = DEF_YEAR_BITS,
	parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          func,
	input  logic [DAY_W-1:0]              day_a,
	input  logic [MON_W-1:0]              month_a,
	input  logic [YEAR_BITS-1:0]          year_a,
	input  logic [DAY_W-1:0]              day_b,
	input  logic [MON_W-1:0]              month_b,
	input  logic [YEAR_BITS-1:0]          year_b,
	input  logic signed [OFFSET_BITS-1:0] offset_days,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [DAY_W-1:0]              res_day,
	output logic [MON_W-1:0]              res_month,
	output logic [YEAR_BITS-1:0]          res_year,
	output logic signed [DIFF_W-1:0]      day_difference,
	output logic                          a_before_b,
	output logic                          a_equals_b,
	output logic [1:0]                    status,
	input  logic                          cfg_we,
	input  logic                          cfg_idx,
	input  logic [CFG_W-1:0]              cfg_data
);

	localparam int NSTG  = 11;
	localparam int DN_W  = dn_width(YEAR_BITS);
	localparam int SUM_W = ((DN_W > OFFSET_BITS) ? DN_W : OFFSET_BITS) + 2;
	localparam int DW    = ((DN_W + 1 > DIFF_W) ? DN_W + 1 : DIFF_W);
	localparam int YC_W  = 17;
	localparam int YEAR_MASK = (1 << YEAR_BITS) - 1;
	localparam logic [CFG_W-1:0] CFG_MASK =
		(YEAR_BITS >= CFG_W) ? {CFG_W{1'b1}} : CFG_W'(YEAR_MASK);
	localparam logic signed [DW-1:0] D_MAX = DW'((1 << (DIFF_W - 1)) - 1);
	localparam logic signed [DW-1:0] D_MIN = DW'(-(1 << (DIFF_W - 1)));

	typedef struct packed {
		func_t             fn;
		logic              earlier;
		logic              equal;
		status_t           st;
		logic [DIFF_W-1:0] diff;
	} side_t;

	// handshake: a stage loads when it is empty or its successor loads
	logic [NSTG:1]   vld_s;
	logic [NSTG+1:1] rdy;

	always_comb begin
		rdy[NSTG+1] = !out_stall;
		for (int k = NSTG; k >= 1; k--)
			rdy[k] = !vld_s[k] || rdy[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (rdy[1])
				vld_s[1] <= in_valid;
			for (int k = 2; k <= NSTG; k++) begin
				if (rdy[k])
					vld_s[k] <= vld_s[k-1];
			end
		end
	end

	assign in_stall  = !rdy[1];
	assign out_valid = vld_s[NSTG];

	// year limits
	logic [CFG_W-1:0] min_year_q, max_year_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_year_q <= CFG_W'(RESET_MIN_YEAR);
			max_year_q <= CFG_W'(RESET_MAX_YEAR);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_MIN_YEAR: min_year_q <= cfg_data & CFG_MASK;
				REG_MAX_YEAR: max_year_q <= cfg_data & CFG_MASK;
				default:      ;
			endcase
		end
	end

	// stages 1 and 2: day numbers of both dates
	logic [DN_W-1:0] dn_a, dn_b;
	logic            ok_a, ok_b;

	gdau_daynum #(.YEAR_BITS(YEAR_BITS)) u_dn_a (
		.clk   (clk),
		.en    (rdy[2:1]),
		.day   (day_a),
		.month (month_a),
		.year  (year_a),
		.dn    (dn_a),
		.ok    (ok_a)
	);

	gdau_daynum #(.YEAR_BITS(YEAR_BITS)) u_dn_b (
		.clk   (clk),
		.en    (rdy[2:1]),
		.day   (day_b),
		.month (month_b),
		.year  (year_b),
		.dn    (dn_b),
		.ok    (ok_b)
	);

	func_t                   func_s1, func_s2;
	logic                    before_s1, before_s2, equal_s1, equal_s2;
	logic signed [OFFSET_BITS-1:0] off_s1, off_s2;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			func_s1   <= func_t'(func);
			before_s1 <= {year_a, month_a, day_a} < {year_b, month_b, day_b};
			equal_s1  <= {year_a, month_a, day_a} == {year_b, month_b, day_b};
			off_s1    <= offset_days;
		end
		if (rdy[2]) begin
			func_s2   <= func_s1;
			before_s2 <= before_s1;
			equal_s2  <= equal_s1;
			off_s2    <= off_s1;
		end
	end

	// stage 3: add offset, difference with saturation, first status
	logic [SUM_W-1:0]     n_sum;
	logic                 n_out;
	logic signed [DW-1:0] d_raw, d_sat;
	side_t                side_nx;

	always_comb begin
		n_sum = SUM_W'(dn_a) + SUM_W'(off_s2);
		n_out = n_sum[SUM_W-1] || (n_sum > SUM_W'(N_MAX));
		d_raw = signed'(DW'(dn_a) - DW'(dn_b));
		if (d_raw > D_MAX)
			d_sat = D_MAX;
		else if (d_raw < D_MIN)
			d_sat = D_MIN;
		else
			d_sat = d_raw;

		side_nx.fn      = func_s2;
		side_nx.earlier = before_s2;
		side_nx.equal   = equal_s2;
		side_nx.diff    = '0;
		if (func_s2 == FUNC_ADD) begin
			if (!ok_a)
				side_nx.st = STAT_BAD_DATE;
			else if (n_out)
				side_nx.st = STAT_RANGE;
			else
				side_nx.st = STAT_OK;
		end else begin
			if (!ok_a || !ok_b) begin
				side_nx.st = STAT_BAD_DATE;
			end else begin
				side_nx.st   = STAT_OK;
				side_nx.diff = DIFF_W'(d_sat);
			end
		end
	end

	side_t          side_s3;
	logic [N_W-1:0] n_s3;
	side_t          side_s [4:10];

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			side_s3 <= side_nx;
			n_s3    <= N_W'(n_sum);
		end
		if (rdy[4])
			side_s[4] <= side_s3;
		for (int k = 5; k <= 10; k++) begin
			if (rdy[k])
				side_s[k] <= side_s[k-1];
		end
	end

	// stages 4 to 10: day number back to a date
	logic [YSH_W-1:0] c_year_sh;
	logic [MON_W-1:0] c_month;
	logic [DAY_W-1:0] c_day;

	gdau_civil u_civil (
		.clk     (clk),
		.en      (rdy[10:4]),
		.n       (n_s3),
		.year_sh (c_year_sh),
		.month   (c_month),
		.day     (c_day)
	);

	// stage 11: year limits and output register
	logic [YC_W-1:0] yfull;
	logic            y_bad, date_ok;
	status_t         st_fin;

	always_comb begin
		yfull  = YC_W'(c_year_sh) - YC_W'(YEAR_SHIFT);
		y_bad  = (c_year_sh < YSH_W'(YEAR_SHIFT)) || (yfull > YC_W'(YEAR_MASK)) ||
			(yfull < YC_W'(min_year_q)) || (yfull > YC_W'(max_year_q));
		st_fin = side_s[10].st;
		if ((side_s[10].fn == FUNC_ADD) && (side_s[10].st == STAT_OK) && y_bad)
			st_fin = STAT_RANGE;
		date_ok = (side_s[10].fn == FUNC_ADD) && (st_fin == STAT_OK);
	end

	logic [DAY_W-1:0]     res_day_s11;
	logic [MON_W-1:0]     res_month_s11;
	logic [YEAR_BITS-1:0] res_year_s11;
	logic [DIFF_W-1:0]    diff_s11;
	logic                 before_s11, equal_s11;
	status_t              status_s11;

	always_ff @(posedge clk) begin
		if (rdy[11]) begin
			res_day_s11   <= date_ok ? c_day : '0;
			res_month_s11 <= date_ok ? c_month : '0;
			res_year_s11  <= date_ok ? YEAR_BITS'(yfull) : '0;
			diff_s11      <= side_s[10].diff;
			before_s11    <= side_s[10].earlier;
			equal_s11     <= side_s[10].equal;
			status_s11    <= st_fin;
		end
	end

	assign res_day        = res_day_s11;
	assign res_month      = res_month_s11;
	assign res_year       = res_year_s11;
	assign day_difference = signed'(diff_s11);
	assign a_before_b     = before_s11;
	assign a_equals_b     = equal_s11;
	assign status         = status_s11;

	// checks
	a_eq_not_before: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && a_equals_b |-> !a_before_b)
		else $error("equal dates reported as ordered");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_BAD_DATE) |->
			(day_difference == '0) && (res_month == '0) && (res_day == '0))
		else $error("invalid date item carries nonzero result");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_RANGE) |-> (res_year == '0) && (day_difference == '0))
		else $error("out of range item carries nonzero result");

	a_date_only_add: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (res_month != '0) |->
			(res_day != '0) && (day_difference == '0) && (status == STAT_OK))
		else $error("result date with bad status or difference");

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s[1] |-> !in_stall)
		else $error("input stalled with empty first stage");

endmodule
